>>> design/imhd_pkg.sv
// ----------------------------------------------------------------------------
// imhd_pkg: shared definitions for the indexed min-heap decrement unit
// Request modes, result status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package imhd_pkg;

  localparam int unsigned KeyW        = 10;
  localparam int unsigned NumKeys     = 1024;
  localparam int unsigned FieldValW   = 16;
  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned DefValBits  = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DEC    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_INS_FAIL  = 2'd2,
    ST_ABSENT    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LK_POS,
    S_LK_HEAP,
    S_POP_ROOT,
    S_POP_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_WR_FINAL,
    S_DONE
  } state_e;

endpackage

>>> design/imhd_ram.sv
// ----------------------------------------------------------------------------
// imhd_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module imhd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/indexed_min_heap_decrement_unit.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrement_unit: indexed binary min-heap with decrease-key
// Holds (key, value) pairs ordered by value, with a key-to-slot position map.
// ----------------------------------------------------------------------------
// Usage: a request carries mode_i (insert, pop minimum, decrement, clear),
// key_i and value_i and is taken when in_valid_i is high and in_stall_o is
// low. Every request gives exactly one result: out_key_o/out_value_o (the
// popped minimum, zero otherwise), status_o and now_empty_o, held with
// out_valid_o until the receiver takes it with out_stall_i low.
// Both the heap and the position map live in single-read, single-write RAMs
// with registered read data; a request is worked off by a sequencer that
// moves a hole through the heap, with a parent read and a compare per level
// on the way up and a left child read, right child read and compare per level
// on the way down.
// One request is in work at a time; the result register lets the next
// request be taken while the previous result waits on a stalled receiver.
// After reset the position map is swept once, one entry per cycle, over all
// 1024 entries; in_stall_o stays high during that sweep.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrement_unit #(
  parameter int unsigned CAPACITY   = imhd_pkg::DefCapacity,
  parameter int unsigned VALUE_BITS = imhd_pkg::DefValBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [imhd_pkg::KeyW-1:0]      key_i,
  input  logic [imhd_pkg::FieldValW-1:0] value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [imhd_pkg::KeyW-1:0]      out_key_o,
  output logic [imhd_pkg::FieldValW-1:0] out_value_o,
  output logic [1:0]                     status_o,
  output logic                           now_empty_o
);

  localparam int unsigned KW  = imhd_pkg::KeyW;
  localparam int unsigned FW  = imhd_pkg::FieldValW;
  localparam int unsigned VW  = VALUE_BITS;
  localparam int unsigned SW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned XW  = SW + 1;
  localparam int unsigned HW  = KW + VW;
  localparam int unsigned NK  = imhd_pkg::NumKeys;

  // Heap RAM and position map RAM.
  logic          h_we;
  logic [SW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rdata;
  logic          p_we;
  logic [KW-1:0] p_waddr, p_raddr;
  logic [SW-1:0] p_wdata, p_rdata;

  imhd_ram #(.Width(HW), .Depth(CAPACITY)) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  imhd_ram #(.Width(SW), .Depth(NK)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  imhd_pkg::state_e state_q, state_d;
  logic [KW-1:0]  init_q, init_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]  idx_q, idx_d;
  logic [1:0]     mode_q, mode_d;
  logic [KW-1:0]  key_q, key_d;
  logic [KW-1:0]  cur_k_q, cur_k_d;
  logic [VW-1:0]  cur_v_q, cur_v_d;
  logic [VW-1:0]  in_v_q, in_v_d;
  logic [HW-1:0]  lk_q, lk_d;
  logic           has_r_q, has_r_d;
  logic [1:0]     st_q, st_d;
  logic [KW-1:0]  ok_q, ok_d;
  logic [VW-1:0]  ov_q, ov_d;
  logic           ovld_q, ovld_d;
  logic [KW-1:0]  rk_q, rk_d;
  logic [FW-1:0]  rv_q, rv_d;
  logic [1:0]     rs_q, rs_d;
  logic           re_q, re_d;

  // Shared decode of the current step.
  logic            accept;
  logic [VW+FW-1:0] in_ext;
  logic            slot_lt, present, full, up_swap, dn_swap, use_r, out_free;
  logic [KW-1:0]   rd_k, lk_k, ch_k;
  logic [VW-1:0]   rd_v, lk_v, ch_v, dec_v;
  logic [SW-1:0]   parent, ch_idx;
  logic [XW-1:0]   l_idx, r_idx;
  logic [VW+FW-1:0] ov_ext;

  assign in_stall_o = (state_q != imhd_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_ext     = {{VW{1'b0}}, value_i};
  assign rd_k       = h_rdata[HW-1:VW];
  assign rd_v       = h_rdata[VW-1:0];
  assign lk_k       = lk_q[HW-1:VW];
  assign lk_v       = lk_q[VW-1:0];
  assign slot_lt    = (CW'(p_rdata) < cnt_q);
  assign present    = (rd_k == key_q);
  assign full       = (cnt_q == CW'(CAPACITY));
  assign parent     = SW'((idx_q - SW'(1)) >> 1);
  assign up_swap    = (rd_v > cur_v_q);
  assign l_idx      = {idx_q, 1'b1};
  assign r_idx      = l_idx + XW'(1);
  assign use_r      = has_r_q && (rd_v < lk_v);
  assign ch_k       = use_r ? rd_k : lk_k;
  assign ch_v       = use_r ? rd_v : lk_v;
  assign ch_idx     = use_r ? SW'(r_idx) : SW'(l_idx);
  assign dn_swap    = (cur_v_q > ch_v);
  assign dec_v      = (rd_v == '0) ? rd_v : rd_v - VW'(1);
  assign out_free   = !ovld_q || !out_stall_i;
  assign ov_ext     = {{FW{1'b0}}, ov_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imhd_pkg::S_INIT: begin
        if (init_q == KW'(NK - 1)) state_d = imhd_pkg::S_IDLE;
      end
      imhd_pkg::S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            imhd_pkg::MODE_INSERT, imhd_pkg::MODE_DEC: state_d = imhd_pkg::S_LK_POS;
            imhd_pkg::MODE_POP: begin
              state_d = (cnt_q == '0) ? imhd_pkg::S_DONE : imhd_pkg::S_POP_ROOT;
            end
            default: state_d = imhd_pkg::S_DONE;
          endcase
        end
      end
      imhd_pkg::S_LK_POS: begin
        if (slot_lt) state_d = imhd_pkg::S_LK_HEAP;
        else if (mode_q == imhd_pkg::MODE_INSERT && !full) state_d = imhd_pkg::S_UP_RD;
        else state_d = imhd_pkg::S_DONE;
      end
      imhd_pkg::S_LK_HEAP: begin
        if (mode_q == imhd_pkg::MODE_INSERT) begin
          state_d = (present || full) ? imhd_pkg::S_DONE : imhd_pkg::S_UP_RD;
        end else begin
          state_d = present ? imhd_pkg::S_UP_RD : imhd_pkg::S_DONE;
        end
      end
      imhd_pkg::S_POP_ROOT: begin
        state_d = (cnt_q == CW'(1)) ? imhd_pkg::S_DONE : imhd_pkg::S_POP_LAST;
      end
      imhd_pkg::S_POP_LAST: state_d = imhd_pkg::S_DN_RDL;
      imhd_pkg::S_UP_RD: begin
        state_d = (idx_q == '0) ? imhd_pkg::S_WR_FINAL : imhd_pkg::S_UP_CMP;
      end
      imhd_pkg::S_UP_CMP: begin
        state_d = up_swap ? imhd_pkg::S_UP_RD : imhd_pkg::S_WR_FINAL;
      end
      imhd_pkg::S_DN_RDL: begin
        state_d = (l_idx >= XW'(cnt_q)) ? imhd_pkg::S_WR_FINAL : imhd_pkg::S_DN_RDR;
      end
      imhd_pkg::S_DN_RDR: state_d = imhd_pkg::S_DN_CMP;
      imhd_pkg::S_DN_CMP: begin
        state_d = dn_swap ? imhd_pkg::S_DN_RDL : imhd_pkg::S_WR_FINAL;
      end
      imhd_pkg::S_WR_FINAL: state_d = imhd_pkg::S_DONE;
      imhd_pkg::S_DONE: begin
        if (out_free) state_d = imhd_pkg::S_IDLE;
      end
      default: state_d = imhd_pkg::S_IDLE;
    endcase
  end

  // Memory controls and datapath.
  always_comb begin
    h_we    = 1'b0;
    h_waddr = idx_q;
    h_wdata = {cur_k_q, cur_v_q};
    h_raddr = '0;
    p_we    = 1'b0;
    p_waddr = cur_k_q;
    p_wdata = idx_q;
    p_raddr = key_i;
    init_d  = init_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    mode_d  = mode_q;
    key_d   = key_q;
    cur_k_d = cur_k_q;
    cur_v_d = cur_v_q;
    in_v_d  = in_v_q;
    lk_d    = lk_q;
    has_r_d = has_r_q;
    st_d    = st_q;
    ok_d    = ok_q;
    ov_d    = ov_q;
    ovld_d  = ovld_q && out_stall_i;
    rk_d    = rk_q;
    rv_d    = rv_q;
    rs_d    = rs_q;
    re_d    = re_q;
    unique case (state_q)
      imhd_pkg::S_INIT: begin
        p_we    = 1'b1;
        p_waddr = init_q;
        p_wdata = '0;
        init_d  = init_q + KW'(1);
      end
      imhd_pkg::S_IDLE: begin
        if (accept) begin
          mode_d = mode_i;
          key_d  = key_i;
          in_v_d = in_ext[VW-1:0];
          ok_d   = '0;
          ov_d   = '0;
          st_d   = imhd_pkg::ST_OK;
          unique case (mode_i)
            imhd_pkg::MODE_INSERT, imhd_pkg::MODE_DEC: ;
            imhd_pkg::MODE_POP: begin
              if (cnt_q == '0) st_d = imhd_pkg::ST_POP_EMPTY;
            end
            default: cnt_d = '0;
          endcase
        end
      end
      imhd_pkg::S_LK_POS: begin
        h_raddr = p_rdata;
        idx_d   = p_rdata;
        if (!slot_lt) begin
          if (mode_q == imhd_pkg::MODE_INSERT) begin
            if (full) begin
              st_d = imhd_pkg::ST_INS_FAIL;
            end else begin
              cur_k_d = key_q;
              cur_v_d = in_v_q;
              idx_d   = SW'(cnt_q);
              cnt_d   = cnt_q + CW'(1);
            end
          end else begin
            st_d = imhd_pkg::ST_ABSENT;
          end
        end
      end
      imhd_pkg::S_LK_HEAP: begin
        if (mode_q == imhd_pkg::MODE_INSERT) begin
          if (present || full) begin
            st_d = imhd_pkg::ST_INS_FAIL;
          end else begin
            cur_k_d = key_q;
            cur_v_d = in_v_q;
            idx_d   = SW'(cnt_q);
            cnt_d   = cnt_q + CW'(1);
          end
        end else if (present) begin
          cur_k_d = key_q;
          cur_v_d = dec_v;
        end else begin
          st_d = imhd_pkg::ST_ABSENT;
        end
      end
      imhd_pkg::S_POP_ROOT: begin
        ok_d    = rd_k;
        ov_d    = rd_v;
        cnt_d   = cnt_q - CW'(1);
        h_raddr = SW'(cnt_q - CW'(1));
      end
      imhd_pkg::S_POP_LAST: begin
        cur_k_d = rd_k;
        cur_v_d = rd_v;
        idx_d   = '0;
      end
      imhd_pkg::S_UP_RD: begin
        h_raddr = parent;
      end
      imhd_pkg::S_UP_CMP: begin
        if (up_swap) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          p_we    = 1'b1;
          p_waddr = rd_k;
          idx_d   = parent;
        end
      end
      imhd_pkg::S_DN_RDL: begin
        h_raddr = SW'(l_idx);
      end
      imhd_pkg::S_DN_RDR: begin
        lk_d    = h_rdata;
        has_r_d = (r_idx < XW'(cnt_q));
        h_raddr = SW'(r_idx);
      end
      imhd_pkg::S_DN_CMP: begin
        if (dn_swap) begin
          h_we    = 1'b1;
          h_wdata = {ch_k, ch_v};
          p_we    = 1'b1;
          p_waddr = ch_k;
          idx_d   = ch_idx;
        end
      end
      imhd_pkg::S_WR_FINAL: begin
        h_we = 1'b1;
        p_we = 1'b1;
      end
      imhd_pkg::S_DONE: begin
        if (out_free) begin
          ovld_d = 1'b1;
          rk_d   = ok_q;
          rv_d   = ov_ext[FW-1:0];
          rs_d   = st_q;
          re_d   = (cnt_q == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imhd_pkg::S_INIT;
      init_q  <= '0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    mode_q  <= mode_d;
    key_q   <= key_d;
    cur_k_q <= cur_k_d;
    cur_v_q <= cur_v_d;
    in_v_q  <= in_v_d;
    lk_q    <= lk_d;
    has_r_q <= has_r_d;
    st_q    <= st_d;
    ok_q    <= ok_d;
    ov_q    <= ov_d;
    rk_q    <= rk_d;
    rv_q    <= rv_d;
    rs_q    <= rs_d;
    re_q    <= re_d;
  end

  assign out_valid_o = ovld_q;
  assign out_key_o   = rk_q;
  assign out_value_o = rv_q;
  assign status_o    = rs_q;
  assign now_empty_o = re_q;

  // The entry count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A clear request empties the heap on the next cycle.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == imhd_pkg::MODE_CLEAR) |=> (cnt_q == '0))
    else $error("clear did not empty the heap");

  // A pop on an empty heap reports an empty heap.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == imhd_pkg::ST_POP_EMPTY) |-> now_empty_o)
    else $error("pop-empty status with nonempty heap");

  // A result is loaded only while a request is in work.
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == imhd_pkg::S_DONE))
    else $error("result produced outside the done step");

endmodule
